FILE: rtl/core/pirbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pirbt_pkg
// Shared types, constants and helpers of the Pronto infrared burst transmitter.
// ----------------------------------------------------------------------------
package pirbt_pkg;

   // default number of words in the code table
   localparam int TABLE_DEPTH = 256;

   // fixed layout of a Pronto code: two sequence lengths, then the bursts
   localparam logic [7:0] SEQ1_LEN_WORD    = 8'd2;
   localparam logic [7:0] SEQ2_LEN_WORD    = 8'd3;
   localparam logic [7:0] FIRST_BURST_WORD = 8'd4;

   // field widths
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 8;
   localparam int WORD_W   = 16;
   localparam int TICK_W   = 17;
   localparam int ENDSUM_W = 19;

   // item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // ticks in one burst word: twice the word, a zero word counts as one
   function automatic logic [TICK_W-1:0] burst_ticks(input logic [WORD_W-1:0] word);
      logic [TICK_W-1:0] ticks;
      if (word == '0) begin
         ticks = TICK_W'(2);
      end else begin
         ticks = {word, 1'b0};
      end
      return ticks;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pirbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pirbt_ram
// Generic single write port, single read port RAM with registered read.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module pirbt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/pronto_ir_burst_transmitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pronto_ir_burst_transmitter_core
// Plays a loaded Pronto code table as an infrared mark/space burst waveform.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one command per item (load a table word,
// start a transmission, or one carrier half-period tick). Every item gives
// exactly one rsp item with the emitter level, the busy flag and the start
// error flag as they stand after that item.
// From req acceptance to rsp_valid an item passes one input register, then
// one result register. An item can be accepted in every cycle while req_stall
// is low; the step is a short add and compare on registered state.
// The code table sits in a RAM with registered read. The next burst word is
// prefetched every cycle from the RAM, with a bypass for a load to that word;
// the two sequence lengths and the first burst word are also kept in
// registers so that a start completes in a single step.
// Reset is synchronous and clears the control state (idle, mask at mark,
// emitter low); table contents are undefined until loaded.
// When rsp_stall is high the result register holds, the input register holds
// one further item, and req_stall rises only once both are full.
// ----------------------------------------------------------------------------
module pronto_ir_burst_transmitter_core #(
   parameter int TABLE_DEPTH = pirbt_pkg::TABLE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pirbt_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [pirbt_pkg::INDEX_W-1:0] req_word_index,
   input  wire logic [pirbt_pkg::WORD_W-1:0]  req_word_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ir_out,
   output logic                               rsp_busy_res,
   output logic                               rsp_start_error
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = $clog2(TABLE_DEPTH + 1);

   // input register
   logic                             in_valid_ff;
   logic [pirbt_pkg::CMD_W-1:0]      in_cmd_ff;
   logic [pirbt_pkg::INDEX_W-1:0]    in_idx_ff;
   logic [pirbt_pkg::WORD_W-1:0]     in_val_ff;

   // result register
   logic                             out_valid_ff;
   logic                             out_ir_ff;
   logic                             out_busy_ff;
   logic                             out_err_ff;

   // transmitter state
   logic [IW-1:0]                    burst_index_ff, burst_index_in;
   logic [IW-1:0]                    end_index_ff, end_index_in;
   logic [pirbt_pkg::TICK_W-1:0]     tick_count_ff, tick_count_in;
   logic [pirbt_pkg::TICK_W-1:0]     burst_length_ff, burst_length_in;
   logic                             carrier_phase_ff, carrier_phase_in;
   logic                             mark_mask_ff, mark_mask_in;
   logic                             running_ff, running_in;
   logic                             ir_level_ff, ir_level_in;
   logic                             err_in;

   // register copies of the fixed header words
   logic [pirbt_pkg::WORD_W-1:0]     seq1_word_ff;
   logic [pirbt_pkg::WORD_W-1:0]     seq2_word_ff;
   logic [pirbt_pkg::WORD_W-1:0]     first_word_ff;

   // prefetch bypass
   logic                             byp_ff, byp_in;
   logic [pirbt_pkg::WORD_W-1:0]     byp_val_ff;

   // handshake and table port signals
   logic                             advance;
   logic                             take;
   logic                             fire;
   logic                             in_range;
   logic                             wr_en;
   logic [31:0]                      widx_ext;
   logic [AW-1:0]                    wr_addr;
   logic [IW-1:0]                    rd_sum;
   logic [AW-1:0]                    rd_addr;
   logic [pirbt_pkg::WORD_W-1:0]     rd_data;
   logic [pirbt_pkg::WORD_W-1:0]     next_word;
   logic [pirbt_pkg::ENDSUM_W-1:0]   end_sum;
   logic [IW-1:0]                    idx_inc;
   logic [pirbt_pkg::TICK_W-1:0]     tick_inc;

   // handshake: result register frees the input register
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign fire      = in_valid_ff && advance;

   // table write
   assign widx_ext = 32'(in_idx_ff);
   assign in_range = widx_ext < 32'(TABLE_DEPTH);
   assign wr_addr  = widx_ext[AW-1:0];
   assign wr_en    = fire && (in_cmd_ff == pirbt_pkg::CMD_LOAD) && in_range;

   // end index from the two sequence lengths
   assign end_sum = pirbt_pkg::ENDSUM_W'(pirbt_pkg::FIRST_BURST_WORD)
                  + {2'b00, seq1_word_ff, 1'b0}
                  + {2'b00, seq2_word_ff, 1'b0};

   assign idx_inc   = burst_index_ff + IW'(1);
   assign tick_inc  = tick_count_ff + pirbt_pkg::TICK_W'(1);
   assign next_word = byp_ff ? byp_val_ff : rd_data;

   // one item step
   always_comb begin
      burst_index_in   = burst_index_ff;
      end_index_in     = end_index_ff;
      tick_count_in    = tick_count_ff;
      burst_length_in  = burst_length_ff;
      carrier_phase_in = carrier_phase_ff;
      mark_mask_in     = mark_mask_ff;
      running_in       = running_ff;
      ir_level_in      = ir_level_ff;
      err_in           = 1'b0;
      if (fire) begin
         case (in_cmd_ff)
            pirbt_pkg::CMD_LOAD: begin
               // table write only, playback goes on
            end
            pirbt_pkg::CMD_START: begin
               if (end_sum > pirbt_pkg::ENDSUM_W'(TABLE_DEPTH)) begin
                  err_in = 1'b1;
               end else begin
                  end_index_in     = end_sum[IW-1:0];
                  burst_index_in   = IW'(pirbt_pkg::FIRST_BURST_WORD);
                  burst_length_in  = pirbt_pkg::burst_ticks(first_word_ff);
                  tick_count_in    = '0;
                  carrier_phase_in = 1'b1;
                  mark_mask_in     = 1'b1;
                  ir_level_in      = 1'b1;
                  running_in       = 1'b1;
               end
            end
            pirbt_pkg::CMD_TICK: begin
               if (running_ff) begin
                  tick_count_in    = tick_inc;
                  ir_level_in      = carrier_phase_ff & mark_mask_ff;
                  carrier_phase_in = !carrier_phase_ff;
                  if (tick_inc == burst_length_ff) begin
                     mark_mask_in   = !mark_mask_ff;
                     tick_count_in  = '0;
                     burst_index_in = idx_inc;
                     if (idx_inc >= end_index_ff) begin
                        ir_level_in      = 1'b0;
                        carrier_phase_in = 1'b0;
                        running_in       = 1'b0;
                     end else begin
                        burst_length_in = pirbt_pkg::burst_ticks(next_word);
                     end
                  end
               end
            end
            default: begin
               // unused command, nothing changes
            end
         endcase
      end
   end

   // prefetch the word after the one now playing
   assign rd_sum  = burst_index_in + IW'(1);
   assign rd_addr = rd_sum[AW-1:0];
   assign byp_in  = wr_en && (wr_addr == rd_addr);

   pirbt_ram #(
      .WIDTH (pirbt_pkg::WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         burst_index_ff   <= '0;
         end_index_ff     <= '0;
         tick_count_ff    <= '0;
         burst_length_ff  <= '0;
         carrier_phase_ff <= 1'b0;
         mark_mask_ff     <= 1'b1;
         running_ff       <= 1'b0;
         ir_level_ff      <= 1'b0;
         byp_ff           <= 1'b0;
      end else begin
         // input register
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         // result register
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         burst_index_ff   <= burst_index_in;
         end_index_ff     <= end_index_in;
         tick_count_ff    <= tick_count_in;
         burst_length_ff  <= burst_length_in;
         carrier_phase_ff <= carrier_phase_in;
         mark_mask_ff     <= mark_mask_in;
         running_ff       <= running_in;
         ir_level_ff      <= ir_level_in;
         byp_ff           <= byp_in;
      end

      // payload, no reset
      if (take) begin
         in_cmd_ff <= req_cmd;
         in_idx_ff <= req_word_index;
         in_val_ff <= req_word_value;
      end
      if (fire) begin
         out_ir_ff   <= ir_level_in;
         out_busy_ff <= running_in;
         out_err_ff  <= err_in;
      end
      byp_val_ff <= in_val_ff;

      // header word copies
      if (wr_en && (in_idx_ff == pirbt_pkg::SEQ1_LEN_WORD)) begin
         seq1_word_ff <= in_val_ff;
      end
      if (wr_en && (in_idx_ff == pirbt_pkg::SEQ2_LEN_WORD)) begin
         seq2_word_ff <= in_val_ff;
      end
      if (wr_en && (in_idx_ff == pirbt_pkg::FIRST_BURST_WORD)) begin
         first_word_ff <= in_val_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_ir_out      = out_ir_ff;
   assign rsp_busy_res    = out_busy_ff;
   assign rsp_start_error = out_err_ff;

endmodule
`default_nettype wire
